// File: sv/next_fit_segment_allocator_assert.svh
// Assertion macros for the segment allocator
`ifndef NEXT_FIT_SEGMENT_ALLOCATOR_ASSERT_SVH
`define NEXT_FIT_SEGMENT_ALLOCATOR_ASSERT_SVH

// a holds in a cycle -> b holds in the same cycle
`define NFSA_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("nfsa check failed");

// a holds in a cycle -> b holds in the next cycle
`define NFSA_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("nfsa check failed");

`endif

// File: sv/nfsa_pkg.sv
package nfsa_pkg;

  localparam int ARENA_BYTES  = 1048576;
  localparam int MAX_SEGMENTS = 64;
  localparam int IDX_W        = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = IDX_W + 1;
  localparam int START_W      = 20;
  localparam int SIZE_W       = 21;
  localparam int HDR_W        = 8;

  localparam logic [CNT_W-1:0]  SEGS_C     = CNT_W'(MAX_SEGMENTS);
  localparam logic [SIZE_W-1:0] ARENA_SIZE = SIZE_W'(ARENA_BYTES);
  localparam logic [HDR_W-1:0]  RESET_HDR  = 8'd32;
  localparam logic [SIZE_W-1:0] RESET_SIZE = SIZE_W'(ARENA_BYTES - 32);
  localparam logic [SIZE_W-1:0] SIZE_MAX   = {SIZE_W{1'b1}};

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_INIT  = 2'd2;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_NOFIT  = 2'd1;
  localparam logic [1:0] STAT_BADOFF = 2'd2;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INIT,
    CELL_SHR,
    CELL_SHL,
    CELL_WRITE
  } cell_op_t;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [SIZE_W-1:0]  size;
    logic               free;
  } seg_t;

  typedef struct packed {
    cell_op_t           op;
    logic [IDX_W-1:0]   k;
    seg_t               wr;
    logic [SIZE_W-1:0]  init_size;
    logic [SIZE_W:0]    req_h;
    logic [START_W-1:0] off;
    logic [HDR_W-1:0]   hdr;
  } cell_ctl_t;

endpackage

// File: sv/next_fit_segment_allocator.sv
// Next-fit segment allocator over a 1 MiB arena, table of 64 segments held
// in a row of cells that shift towards either neighbour for insert/remove.
// Command channel: cmd, req_size, payload_offset are taken when start is
// high and busy is low. busy stays high until the result is out.
// Result channel: status, grant_offset, free_bytes, used_bytes are valid
// for the single cycle that done is high; there is no back-pressure.
// Config channel: cfg_valid/cfg_ready/cfg_data writes header_bytes; ready
// is always high, write only while no command is in flight.
// Operation with n live segments: an allocate scans one segment a cycle from
// the cursor (up to n segments), then updates the table; a free scans from
// entry zero (up to n segments), then updates the table. All commands end
// with a totals pass over the cell row read port; one command at a time.
// Reset: synchronous, one free segment of arena minus 32 bytes, header 32,
// cursor zero, totals set; the first command is taken the cycle after.
module next_fit_segment_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [20:0] req_size,
  input  logic [19:0] payload_offset,
  output logic        done,
  output logic [1:0]  status,
  output logic [19:0] grant_offset,
  output logic [20:0] free_bytes,
  output logic [20:0] used_bytes,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  `include "next_fit_segment_allocator_assert.svh"

  typedef enum logic [4:0] {
    S_IDLE, S_WAIT, S_INIT,
    S_A_SCAN, S_A_DEC, S_A_SPLIT, S_A_WNEW, S_A_WOLD,
    S_F_SCAN, S_F_MARK, S_F_UP, S_F_UPW, S_F_UPS, S_F_LOPREP, S_F_LO,
    S_F_LOW, S_F_LOS,
    S_SUM0, S_SUM1, S_SUM_RUN
  } state_t;

  state_t state, ret;

  logic [nfsa_pkg::HDR_W-1:0]   hdr;
  logic [nfsa_pkg::CNT_W-1:0]   count, n;
  logic [nfsa_pkg::IDX_W-1:0]   cursor, idx, scan_idx, rd_idx;
  nfsa_pkg::seg_t               rd, sel;
  logic [nfsa_pkg::SIZE_W-1:0]  req;
  logic [nfsa_pkg::START_W-1:0] off;
  logic [nfsa_pkg::SIZE_W:0]    req_h;
  logic                         split;
  logic [1:0]                   stat;
  logic [nfsa_pkg::START_W-1:0] grant;
  logic [nfsa_pkg::SIZE_W-1:0]  acc_f, acc_u, free_total, used_total;

  nfsa_pkg::cell_ctl_t          ctl;
  nfsa_pkg::seg_t               segs [nfsa_pkg::MAX_SEGMENTS];
  logic [nfsa_pkg::MAX_SEGMENTS-1:0] fit_vec, hit_vec;

  // row of cells
  for (genvar g = 0; g < nfsa_pkg::MAX_SEGMENTS; g++) begin : g_cell
    nfsa_pkg::seg_t lft, rgt;
    if (g == 0) begin : g_first
      assign lft = segs[g];
    end else begin : g_mid_l
      assign lft = segs[g-1];
    end
    if (g == nfsa_pkg::MAX_SEGMENTS - 1) begin : g_last
      assign rgt = segs[g];
    end else begin : g_mid_r
      assign rgt = segs[g+1];
    end
    nfsa_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .pos   (nfsa_pkg::IDX_W'(g)),
      .ctl   (ctl),
      .left  (lft),
      .right (rgt),
      .seg   (segs[g]),
      .fit   (fit_vec[g]),
      .hit   (hit_vec[g])
    );
  end

  // arithmetic on the selected segments
  logic [21:0] end_sel, end_rd, merged_up, merged_lo;
  logic [20:0] new_start_w;
  logic [22:0] new_size_w, split_lim;
  logic        split_c, up_ok, lo_ok;
  logic [nfsa_pkg::CNT_W-1:0] idx_nxt;
  logic [nfsa_pkg::IDX_W-1:0] cur_eff;
  logic [21:0] sum_f, sum_u;
  logic [nfsa_pkg::SIZE_W-1:0] acc_f_next, acc_u_next;

  assign end_sel     = {2'b0, sel.start} + {14'b0, hdr} + {1'b0, sel.size};
  assign end_rd      = {2'b0, rd.start} + {14'b0, hdr} + {1'b0, rd.size};
  assign merged_up   = {1'b0, sel.size} + {14'b0, hdr} + {1'b0, rd.size};
  assign merged_lo   = {1'b0, rd.size} + {14'b0, hdr} + {1'b0, sel.size};
  assign new_start_w = {1'b0, sel.start} + {13'b0, hdr} + req;
  assign new_size_w  = {2'b0, sel.size} - {2'b0, req} - {15'b0, hdr};
  assign split_lim   = {1'b0, req_h} + {15'b0, hdr};
  assign split_c     = ({2'b0, rd.size} > split_lim) && (count < nfsa_pkg::SEGS_C);
  assign idx_nxt     = {1'b0, idx} + 7'd1;
  assign up_ok       = (idx_nxt < count) && rd.free && (end_sel == {2'b0, rd.start});
  assign lo_ok       = (idx != '0) && rd.free && (end_rd == {2'b0, sel.start});
  assign cur_eff     = ({1'b0, cursor} >= count) ? '0 : cursor;

  assign sum_f      = {1'b0, acc_f} + {1'b0, rd.size};
  assign sum_u      = {1'b0, acc_u} + {1'b0, rd.size};
  assign acc_f_next = !rd.free ? acc_f : (sum_f[21] ? nfsa_pkg::SIZE_MAX : sum_f[20:0]);
  assign acc_u_next = rd.free ? acc_u : (sum_u[21] ? nfsa_pkg::SIZE_MAX : sum_u[20:0]);

  // broadcast to the cell row
  always_comb begin
    ctl           = '0;
    ctl.op        = nfsa_pkg::CELL_HOLD;
    ctl.init_size = nfsa_pkg::ARENA_SIZE - {13'b0, hdr};
    ctl.req_h     = req_h;
    ctl.off       = off;
    ctl.hdr       = hdr;
    unique case (state)
      S_INIT: ctl.op = nfsa_pkg::CELL_INIT;
      S_A_SPLIT: begin
        ctl.op = nfsa_pkg::CELL_SHR;
        ctl.k  = idx + 6'd1;
      end
      S_A_WNEW: begin
        ctl.op       = nfsa_pkg::CELL_WRITE;
        ctl.k        = idx + 6'd1;
        ctl.wr.start = new_start_w[19:0];
        ctl.wr.size  = new_size_w[20:0];
        ctl.wr.free  = 1'b1;
      end
      S_A_WOLD: begin
        ctl.op       = nfsa_pkg::CELL_WRITE;
        ctl.k        = idx;
        ctl.wr.start = sel.start;
        ctl.wr.size  = split ? req : sel.size;
        ctl.wr.free  = 1'b0;
      end
      S_F_MARK: begin
        ctl.op       = nfsa_pkg::CELL_WRITE;
        ctl.k        = idx;
        ctl.wr.start = rd.start;
        ctl.wr.size  = rd.size;
        ctl.wr.free  = 1'b1;
      end
      S_F_UPW: begin
        ctl.op = nfsa_pkg::CELL_WRITE;
        ctl.k  = idx;
        ctl.wr = sel;
      end
      S_F_UPS: begin
        ctl.op = nfsa_pkg::CELL_SHL;
        ctl.k  = idx + 6'd1;
      end
      S_F_LOW: begin
        ctl.op = nfsa_pkg::CELL_WRITE;
        ctl.k  = idx - 6'd1;
        ctl.wr = sel;
      end
      S_F_LOS: begin
        ctl.op = nfsa_pkg::CELL_SHL;
        ctl.k  = idx;
      end
      default: ;
    endcase
  end

  // single read port of the row, registered
  always_ff @(posedge clk) begin
    rd <= segs[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ret        <= S_IDLE;
      hdr        <= nfsa_pkg::RESET_HDR;
      count      <= 7'd1;
      cursor     <= '0;
      free_total <= nfsa_pkg::RESET_SIZE;
      used_total <= '0;
      done       <= 1'b0;
      rd_idx     <= '0;
      stat       <= nfsa_pkg::STAT_OK;
      grant      <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_valid) hdr <= cfg_data;
      unique case (state)
        S_IDLE: if (start) begin
          stat  <= nfsa_pkg::STAT_OK;
          grant <= '0;
          n     <= '0;
          if (cmd == nfsa_pkg::CMD_ALLOC) begin
            req      <= req_size;
            req_h    <= {1'b0, req_size} + {14'b0, hdr};
            cursor   <= cur_eff;
            scan_idx <= cur_eff;
            state    <= S_A_SCAN;
          end else if (cmd == nfsa_pkg::CMD_FREE) begin
            off      <= payload_offset;
            scan_idx <= '0;
            state    <= S_F_SCAN;
          end else if (cmd == nfsa_pkg::CMD_INIT) begin
            state <= S_INIT;
          end else begin
            state <= S_SUM0;
          end
        end
        S_WAIT: state <= ret;
        S_INIT: begin
          count  <= 7'd1;
          cursor <= '0;
          state  <= S_SUM0;
        end
        S_A_SCAN: begin
          if (fit_vec[scan_idx]) begin
            idx    <= scan_idx;
            rd_idx <= scan_idx;
            ret    <= S_A_DEC;
            state  <= S_WAIT;
          end else if (n + 7'd1 == count) begin
            stat  <= nfsa_pkg::STAT_NOFIT;
            state <= S_SUM0;
          end else begin
            n        <= n + 7'd1;
            scan_idx <= ({1'b0, scan_idx} + 7'd1 == count) ? '0 : scan_idx + 6'd1;
          end
        end
        S_A_DEC: begin
          sel   <= rd;
          split <= split_c;
          grant <= rd.start + {12'b0, hdr};
          state <= split_c ? S_A_SPLIT : S_A_WOLD;
        end
        S_A_SPLIT: state <= S_A_WNEW;
        S_A_WNEW: begin
          count <= count + 7'd1;
          state <= S_A_WOLD;
        end
        S_A_WOLD: begin
          cursor <= (idx_nxt >= count) ? '0 : idx_nxt[nfsa_pkg::IDX_W-1:0];
          state  <= S_SUM0;
        end
        S_F_SCAN: begin
          if (hit_vec[scan_idx]) begin
            idx    <= scan_idx;
            rd_idx <= scan_idx;
            ret    <= S_F_MARK;
            state  <= S_WAIT;
          end else if (n + 7'd1 == count) begin
            stat  <= nfsa_pkg::STAT_BADOFF;
            state <= S_SUM0;
          end else begin
            n        <= n + 7'd1;
            scan_idx <= scan_idx + 6'd1;
          end
        end
        S_F_MARK: begin
          sel      <= '{start: rd.start, size: rd.size, free: 1'b1};
          rd_idx   <= idx + 6'd1;
          ret      <= S_F_UP;
          state    <= S_WAIT;
        end
        S_F_UP: begin
          if (up_ok) begin
            sel.size <= merged_up[20:0];
            state    <= S_F_UPW;
          end else begin
            state <= S_F_LOPREP;
          end
        end
        S_F_UPW: state <= S_F_UPS;
        S_F_UPS: begin
          count <= count - 7'd1;
          state <= S_F_LOPREP;
        end
        S_F_LOPREP: begin
          rd_idx <= idx - 6'd1;
          ret    <= S_F_LO;
          state  <= S_WAIT;
        end
        S_F_LO: begin
          if (lo_ok) begin
            sel.start <= rd.start;
            sel.size  <= merged_lo[20:0];
            sel.free  <= 1'b1;
            state     <= S_F_LOW;
          end else begin
            cursor <= idx;
            state  <= S_SUM0;
          end
        end
        S_F_LOW: state <= S_F_LOS;
        S_F_LOS: begin
          count  <= count - 7'd1;
          idx    <= idx - 6'd1;
          cursor <= idx - 6'd1;
          state  <= S_SUM0;
        end
        S_SUM0: begin
          rd_idx <= '0;
          acc_f  <= '0;
          acc_u  <= '0;
          n      <= '0;
          state  <= S_SUM1;
        end
        S_SUM1: begin
          rd_idx <= rd_idx + 6'd1;
          state  <= S_SUM_RUN;
        end
        S_SUM_RUN: begin
          // rd trails rd_idx by one entry
          rd_idx <= rd_idx + 6'd1;
          acc_f  <= acc_f_next;
          acc_u  <= acc_u_next;
          n      <= n + 7'd1;
          if (n + 7'd1 == count) begin
            free_total <= acc_f_next;
            used_total <= acc_u_next;
            done       <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy         = (state != S_IDLE);
  assign cfg_ready    = 1'b1;
  assign status       = stat;
  assign grant_offset = grant;
  assign free_bytes   = free_total;
  assign used_bytes   = used_total;

  `NFSA_ASSERT_IMP(a_count_range, 1'b1, (count != '0) && (count <= nfsa_pkg::SEGS_C))
  `NFSA_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  `NFSA_ASSERT_IMP(a_cursor_live, state == S_IDLE, {1'b0, cursor} < count)

endmodule

// File: sv/nfsa_cell.sv
module nfsa_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [nfsa_pkg::IDX_W-1:0]  pos,
  input  nfsa_pkg::cell_ctl_t         ctl,
  input  nfsa_pkg::seg_t              left,
  input  nfsa_pkg::seg_t              right,
  output nfsa_pkg::seg_t              seg,
  output logic                        fit,
  output logic                        hit
);

  always_ff @(posedge clk) begin
    if (rst) begin
      seg.start <= '0;
      seg.size  <= nfsa_pkg::RESET_SIZE;
      seg.free  <= (pos == '0);
    end else begin
      unique case (ctl.op)
        nfsa_pkg::CELL_INIT: begin
          seg.start <= '0;
          seg.size  <= ctl.init_size;
          seg.free  <= (pos == '0);
        end
        nfsa_pkg::CELL_SHR: if (pos > ctl.k) seg <= left;
        nfsa_pkg::CELL_SHL: if (pos >= ctl.k) seg <= right;
        nfsa_pkg::CELL_WRITE: if (pos == ctl.k) seg <= ctl.wr;
        default: ;
      endcase
    end
  end

  assign fit = seg.free && ({1'b0, seg.size} >= ctl.req_h);
  assign hit = !seg.free && (({1'b0, seg.start} + {13'b0, ctl.hdr}) == {1'b0, ctl.off});

endmodule

// File: test/nfsa_checker.sv
module nfsa_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  cmd,
  input  logic [20:0] req_size,
  input  logic [19:0] payload_offset,
  input  logic        done,
  input  logic [1:0]  status,
  input  logic [19:0] grant_offset,
  input  logic [20:0] free_bytes,
  input  logic [20:0] used_bytes,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  status;
    logic [19:0] grant;
    logic [20:0] free_b;
    logic [20:0] used_b;
  } alloc_word_t;

  alloc_word_t expected_q[$];

  logic [7:0]  hdr;
  logic [19:0] sstart [nfsa_pkg::MAX_SEGMENTS];
  logic [20:0] ssize  [nfsa_pkg::MAX_SEGMENTS];
  logic        sfree  [nfsa_pkg::MAX_SEGMENTS];
  int          nseg;
  int          cursor;

  function automatic void arena_clear();
    for (int i = 0; i < nfsa_pkg::MAX_SEGMENTS; i++) begin
      sstart[i] = '0;
      ssize[i]  = '0;
      sfree[i]  = 1'b0;
    end
    ssize[0] = 21'(longint'(nfsa_pkg::ARENA_BYTES) - hdr);
    sfree[0] = 1'b1;
    nseg = 1;
    cursor = 0;
  endfunction

  function automatic void drop_seg(int k);
    for (int i = k; i + 1 < nseg; i++) begin
      sstart[i] = sstart[i+1];
      ssize[i]  = ssize[i+1];
      sfree[i]  = sfree[i+1];
    end
    nseg--;
  endfunction

  function automatic bit touching(int lo, int hi);
    longint e;
    e = longint'(sstart[lo]) + hdr + ssize[lo];
    return e == longint'(sstart[hi]);
  endfunction

  function automatic alloc_word_t predict_alloc(logic [1:0] c, logic [20:0] rq,
                                                logic [19:0] off);
    alloc_word_t w;
    longint      rh, f, u;
    int          idx, j;
    bit          found;
    w = '0;
    rh = longint'(rq) + hdr;
    if (c == nfsa_pkg::CMD_ALLOC) begin
      if (cursor >= nseg) cursor = 0;
      idx = cursor;
      found = 0;
      for (int n = 0; n < nseg; n++) begin
        if (sfree[idx] && longint'(ssize[idx]) >= rh) begin
          found = 1;
          break;
        end
        idx++;
        if (idx >= nseg) idx = 0;
      end
      if (!found) begin
        w.status = nfsa_pkg::STAT_NOFIT;
      end else begin
        if (longint'(ssize[idx]) > rh + hdr && nseg < nfsa_pkg::MAX_SEGMENTS) begin
          for (int i = nseg; i > idx + 1; i--) begin
            sstart[i] = sstart[i-1];
            ssize[i]  = ssize[i-1];
            sfree[i]  = sfree[i-1];
          end
          sstart[idx+1] = 20'(longint'(sstart[idx]) + rh);
          ssize[idx+1]  = 21'(longint'(ssize[idx]) - rh);
          sfree[idx+1]  = 1'b1;
          nseg++;
          ssize[idx] = rq;
        end
        sfree[idx] = 1'b0;
        w.grant = 20'(longint'(sstart[idx]) + hdr);
        w.status = nfsa_pkg::STAT_OK;
        cursor = idx + 1;
        if (cursor >= nseg) cursor = 0;
      end
    end else if (c == nfsa_pkg::CMD_FREE) begin
      found = 0;
      for (j = 0; j < nseg; j++)
        if (!sfree[j] && longint'(sstart[j]) + hdr == longint'(off)) begin
          found = 1;
          break;
        end
      if (!found) begin
        w.status = nfsa_pkg::STAT_BADOFF;
      end else begin
        sfree[j] = 1'b1;
        if (j + 1 < nseg && sfree[j+1] && touching(j, j + 1)) begin
          ssize[j] = 21'(longint'(ssize[j]) + hdr + ssize[j+1]);
          drop_seg(j + 1);
        end
        if (j > 0 && sfree[j-1] && touching(j - 1, j)) begin
          ssize[j-1] = 21'(longint'(ssize[j-1]) + hdr + ssize[j]);
          drop_seg(j);
          j--;
        end
        cursor = j;
      end
    end else if (c == nfsa_pkg::CMD_INIT) begin
      arena_clear();
    end
    f = 0;
    u = 0;
    for (int i = 0; i < nseg; i++)
      if (sfree[i]) f += ssize[i]; else u += ssize[i];
    w.free_b = (f > 64'h1FFFFF) ? nfsa_pkg::SIZE_MAX : 21'(f);
    w.used_b = (u > 64'h1FFFFF) ? nfsa_pkg::SIZE_MAX : 21'(u);
    return w;
  endfunction

  alloc_word_t got, want;

  always @(posedge clk) begin
    if (rst) begin
      hdr = nfsa_pkg::RESET_HDR;
      arena_clear();
      expected_q.delete();
      errors <= 0;
    end else begin
      if (cfg_valid && cfg_ready) hdr = cfg_data;
      if (start && !busy) expected_q.push_back(predict_alloc(cmd, req_size, payload_offset));
      if (done) begin
        got = {status, grant_offset, free_bytes, used_bytes};
        if (expected_q.size() == 0) begin
          if (errors < 10) $display("unexpected result word %h", got);
          errors <= errors + 1;
        end else begin
          want = expected_q.pop_front();
          if (got != want) begin
            if (errors < 10)
              $display("mismatch: want st=%0d g=%h f=%0d u=%0d, got st=%0d g=%h f=%0d u=%0d",
                       want.status, want.grant, want.free_b, want.used_b,
                       got.status, got.grant, got.free_b, got.used_b);
            errors <= errors + 1;
          end
        end
      end
    end
    pending = expected_q.size();
  end
endmodule

// File: test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // opcode with no defined action
  localparam logic [1:0] CMD_SPARE = 2'd3;

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  logic [1:0]  cmd = nfsa_pkg::CMD_INIT;
  logic [20:0] req_size = '0;
  logic [19:0] payload_offset = '0;
  logic        done;
  logic [1:0]  status;
  logic [19:0] grant_offset;
  logic [20:0] free_bytes, used_bytes;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;
  int          errors, pending;
  int          gap_pct;
  logic [19:0] grants[$];

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  next_fit_segment_allocator dut (.*);

  nfsa_checker chk (.*);

  task automatic send_cmd(logic [1:0] c, logic [20:0] rq, logic [19:0] off);
    while (gap_pct > 0 && $urandom_range(99, 0) < gap_pct) @(posedge clk);
    start <= 1;
    cmd <= c;
    req_size <= rq;
    payload_offset <= off;
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 0;
    // catch the grant for later frees
    while (!done) @(posedge clk);
    if (c == nfsa_pkg::CMD_ALLOC && status == nfsa_pkg::STAT_OK) grants.push_back(grant_offset);
    @(posedge clk);
  endtask

  task automatic write_hdr(logic [7:0] h);
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= h;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic random_cmd();
    int r, k;
    logic [20:0] rq;
    r = $urandom_range(99, 0);
    if ($urandom_range(9, 0) == 0) rq = 21'($urandom_range(21'h1FFFFF, 0));
    else rq = 21'($urandom_range(40000, 0));
    if (r < 50) begin
      send_cmd(nfsa_pkg::CMD_ALLOC, rq, 20'($urandom));
    end else if (r < 85 && grants.size() > 0) begin
      k = $urandom_range(grants.size() - 1, 0);
      send_cmd(nfsa_pkg::CMD_FREE, 21'($urandom), grants[k]);
      grants.delete(k);
    end else if (r < 93) begin
      send_cmd(nfsa_pkg::CMD_FREE, 21'($urandom), 20'($urandom));
    end else if (r < 97) begin
      send_cmd(CMD_SPARE, 21'($urandom), 20'($urandom));
    end else begin
      send_cmd(nfsa_pkg::CMD_INIT, 21'($urandom), 20'($urandom));
      grants.delete();
    end
  endtask

  initial begin
    gap_pct = 0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: edges, bad frees, merges, unused opcode, full table
    send_cmd(nfsa_pkg::CMD_ALLOC, 21'd0, 20'd0);
    send_cmd(nfsa_pkg::CMD_ALLOC, 21'h1FFFFF, 20'hFFFFF);
    send_cmd(nfsa_pkg::CMD_ALLOC, 21'd100, 20'd0);
    send_cmd(nfsa_pkg::CMD_ALLOC, 21'd200, 20'd0);
    send_cmd(nfsa_pkg::CMD_FREE, 21'd0, 20'd0);
    send_cmd(nfsa_pkg::CMD_FREE, 21'h1FFFFF, 20'hFFFFF);
    send_cmd(nfsa_pkg::CMD_FREE, 21'd0, 20'd64);
    send_cmd(nfsa_pkg::CMD_FREE, 21'd0, 20'd196);
    send_cmd(nfsa_pkg::CMD_FREE, 21'd0, 20'd32);
    send_cmd(CMD_SPARE, 21'h1FFFFF, 20'hFFFFF);
    send_cmd(nfsa_pkg::CMD_ALLOC, 21'd1048544, 20'd0);
    send_cmd(nfsa_pkg::CMD_ALLOC, 21'd1, 20'd0);
    send_cmd(nfsa_pkg::CMD_INIT, 21'd0, 20'd0);
    for (int i = 0; i < 70; i++) send_cmd(nfsa_pkg::CMD_ALLOC, 21'd8, 20'd0);
    send_cmd(nfsa_pkg::CMD_INIT, 21'd0, 20'd0);
    grants.delete();
    write_hdr(8'd0);
    send_cmd(nfsa_pkg::CMD_ALLOC, 21'd1048576, 20'd0);
    send_cmd(nfsa_pkg::CMD_FREE, 21'd0, 20'd0);
    write_hdr(8'd255);
    send_cmd(nfsa_pkg::CMD_INIT, 21'd0, 20'd0);
    for (int p = 0; p < 3; p++) begin
      gap_pct = (p == 0) ? 36 : (p == 1) ? 63 : 0;
      for (int i = 0; i < 230; i++) random_cmd();
      write_hdr((p == 0) ? 8'd0 : (p == 1) ? 8'($urandom) : 8'd32);
    end
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb NOT OK");
    $finish;
  end
endmodule
